FILE: rtl/bfc_pkg.sv
// Shared widths, register codes, the work-item struct and the reciprocal table of the box filter.
package bfc_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int CMP_W      = 13;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int COLSUM_W   = 10;
  localparam int SUM_W      = 12;
  localparam int RECIP_W    = 17;
  localparam int RECIP_SHIFT = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd768;

  // One mean to compute: up to three column sums, the clipped window shape and its tags.
  typedef struct packed {
    logic [COLSUM_W-1:0] opnd0;
    logic [COLSUM_W-1:0] opnd1;
    logic [COLSUM_W-1:0] opnd2;
    logic [1:0]          rows;
    logic [1:0]          cols;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic                last;
    logic                done;
  } job_t;

  // Reciprocal of the pixel count, scaled by 2^16; exact for sums below 2^15.
  function automatic logic [RECIP_W-1:0] recip_of(input logic [1:0] rows,
                                                  input logic [1:0] cols);
    logic [3:0] divisor;
    logic [RECIP_W-1:0] recip;
    divisor = {2'b00, rows} * {2'b00, cols};
    unique case (divisor)
      4'd1:    recip = 17'd65536;
      4'd2:    recip = 17'd32768;
      4'd3:    recip = 17'd21846;
      4'd4:    recip = 17'd16384;
      4'd6:    recip = 17'd10923;
      4'd9:    recip = 17'd7282;
      default: recip = '0;
    endcase
    return recip;
  endfunction

endpackage

FILE: rtl/bfc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module bfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/bfc_mean.sv
// Two-stage mean unit: window sum and reciprocal select, then multiply into the result register.
module bfc_mean
  import bfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  job_t             job,
  output logic             job_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] smoothed,
  output logic [ROW_W-1:0] out_row,
  output logic [COL_W-1:0] out_col,
  output logic             last_of_run,
  output logic             frame_done
);

  localparam int PROD_W = SUM_W + RECIP_W;

  logic               a_valid_r;
  logic [SUM_W-1:0]   a_sum_r;
  logic [RECIP_W-1:0] a_recip_r;
  logic [ROW_W-1:0]   a_row_r;
  logic [COL_W-1:0]   a_col_r;
  logic               a_last_r;
  logic               a_done_r;

  logic               out_valid_r;
  logic [PIX_W-1:0]   smoothed_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [COL_W-1:0]   out_col_r;
  logic               last_r;
  logic               done_r;

  logic               b_free;
  logic               a_adv;
  logic               a_load;
  logic [PROD_W-1:0]  prod;

  assign b_free    = !out_valid_r || !out_stall;
  assign a_adv     = a_valid_r && b_free;
  assign job_ready = !a_valid_r || a_adv;
  assign a_load    = job_valid && job_ready;
  assign prod      = PROD_W'(a_sum_r) * PROD_W'(a_recip_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_adv) begin
        out_valid_r <= 1'b1;
      end else if (b_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_sum_r   <= SUM_W'(job.opnd0) + SUM_W'(job.opnd1) + SUM_W'(job.opnd2);
      a_recip_r <= recip_of(job.rows, job.cols);
      a_row_r   <= job.row;
      a_col_r   <= job.col;
      a_last_r  <= job.last;
      a_done_r  <= job.done;
    end
    if (a_adv) begin
      smoothed_r <= prod[RECIP_SHIFT +: PIX_W];
      out_row_r  <= a_row_r;
      out_col_r  <= a_col_r;
      last_r     <= a_last_r;
      done_r     <= a_done_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign smoothed    = smoothed_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign last_of_run = last_r;
  assign frame_done  = done_r;

endmodule

FILE: rtl/box_filter_3x3_clamped_mean_unit.sv
// Top level of the streaming 3x3 box filter with border-clipped mean.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_pixel_in
//   out      output     out_valid/out_stall  out_smoothed, out_out_row, out_out_col,
//                                            out_last_of_run, out_frame_done
//   cfg      input      cfg_we               cfg_idx, cfg_wdata
//
// An item's time is set by the read-modify-write of the line memory and the job issue,
// one job per cycle for each result it causes while the mean unit takes them.
// The mean unit holds up to two results in flight, so the next item is taken while
// the previous results still drain. Reset is synchronous and active low; it clears
// the counters and column sums and resets the configuration. A stall on the
// result side holds the result register and backs up into the job issue; the input
// stays stalled until every result of the current item has entered the mean unit.
module box_filter_3x3_clamped_mean_unit
  import bfc_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_pixel_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_smoothed,
  output logic [ROW_W-1:0]      out_out_row,
  output logic [COL_W-1:0]      out_out_col,
  output logic                  out_last_of_run,
  output logic                  out_frame_done,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LINE_W = 2 * PIX_W;
  localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);
  localparam logic [CMP_W-1:0] MAX_H_C = CMP_W'(MAX_HEIGHT);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [FW_W-1:0]     frame_width_r;
  logic [FH_W-1:0]     frame_height_r;
  logic [ROW_W-1:0]    row_cnt_r, row_cnt_nxt;
  logic [CW-1:0]       col_cnt_r, col_cnt_nxt;
  logic [PIX_W-1:0]    px_r;
  logic [ROW_W-1:0]    r_r;
  logic [CW-1:0]       c_r;
  logic [COLSUM_W-1:0] win_r [3];
  logic [COLSUM_W-1:0] low_r [3];
  logic [3:0]          pend_r, pend_nxt;
  logic                done_r;

  logic [CMP_W-1:0]    w_eff, h_eff, fw_ext, fh_ext;
  logic                restart;
  logic [CW-1:0]       start_c;
  logic [ROW_W-1:0]    start_r;
  logic                in_acc;

  logic [LINE_W-1:0]   rd_line;
  logic [PIX_W-1:0]    recent, older, above, above2;
  logic [COLSUM_W-1:0] up_sum, lo_sum;
  logic                r_ge1, r_ge2, c_ge1, c_ge2;
  logic                row_end, last_row;
  logic [3:0]          mask;
  logic                load;

  logic [1:0]          sel;
  logic [3:0]          pend_clr;
  logic                upper, at_end;
  logic [COLSUM_W-1:0] s0, s1, s2;
  logic [CMP_W-1:0]    c_emit;
  job_t                job;
  logic                job_valid, job_ready, job_take;

  // Frame size as used: zero acts as one, oversize clips to the limits.
  assign fw_ext = CMP_W'(frame_width_r);
  assign fh_ext = CMP_W'(frame_height_r);

  always_comb begin
    priority if (fw_ext == '0) begin
      w_eff = CMP_W'(1);
    end else if (fw_ext > MAX_W_C) begin
      w_eff = MAX_W_C;
    end else begin
      w_eff = fw_ext;
    end
    priority if (fh_ext == '0) begin
      h_eff = CMP_W'(1);
    end else if (fh_ext > MAX_H_C) begin
      h_eff = MAX_H_C;
    end else begin
      h_eff = fh_ext;
    end
  end

  // A position that falls outside a newly written size restarts the frame.
  assign restart = (CMP_W'(col_cnt_r) >= w_eff) || (CMP_W'(row_cnt_r) >= h_eff);
  assign start_c = restart ? '0 : col_cnt_r;
  assign start_r = restart ? '0 : row_cnt_r;

  assign in_stall = !rst_n || (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load     = (state_r == ST_LOAD);

  // Each entry holds the column's two most recent rows: older above, recent below.
  bfc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (load),
    .waddr (c_r),
    .wdata ({recent, px_r}),
    .re    (in_acc),
    .raddr (start_c),
    .rdata (rd_line)
  );

  assign recent = rd_line[PIX_W-1:0];
  assign older  = rd_line[LINE_W-1:PIX_W];

  assign r_ge1 = (r_r != '0);
  assign r_ge2 = (r_r >= ROW_W'(2));
  assign c_ge1 = (c_r != '0);
  assign c_ge2 = (CMP_W'(c_r) >= CMP_W'(2));

  assign above  = r_ge1 ? recent : '0;
  assign above2 = r_ge2 ? older  : '0;
  assign up_sum = COLSUM_W'(above2) + COLSUM_W'(above) + COLSUM_W'(px_r);
  assign lo_sum = COLSUM_W'(above) + COLSUM_W'(px_r);

  assign row_end  = (CMP_W'(c_r) + CMP_W'(1)) == w_eff;
  assign last_row = (CMP_W'(r_r) + CMP_W'(1)) == h_eff;

  // Results of this pixel: upper window inside and at row end, then the last row's.
  assign mask = {last_row && row_end, last_row && c_ge1, r_ge1 && row_end, r_ge1 && c_ge1};

  // Issue the pending results lowest first.
  always_comb begin
    priority if (pend_r[0]) begin
      sel = 2'd0;
    end else if (pend_r[1]) begin
      sel = 2'd1;
    end else if (pend_r[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  always_comb begin
    pend_clr      = pend_r;
    pend_clr[sel] = 1'b0;
  end

  assign upper  = !sel[1];
  assign at_end = sel[0];
  assign s0 = upper ? win_r[0] : low_r[0];
  assign s1 = upper ? win_r[1] : low_r[1];
  assign s2 = upper ? win_r[2] : low_r[2];
  assign c_emit = at_end ? CMP_W'(c_r) : (CMP_W'(c_r) - CMP_W'(1));

  always_comb begin
    job.opnd2 = s2;
    if (at_end) begin
      job.opnd0 = '0;
      job.opnd1 = c_ge1 ? s1 : '0;
      job.cols  = c_ge1 ? 2'd2 : 2'd1;
    end else begin
      job.opnd0 = c_ge2 ? s0 : '0;
      job.opnd1 = s1;
      job.cols  = c_ge2 ? 2'd3 : 2'd2;
    end
    if (upper) begin
      job.rows = r_ge2 ? 2'd3 : 2'd2;
      job.row  = r_r - ROW_W'(1);
    end else begin
      job.rows = r_ge1 ? 2'd2 : 2'd1;
      job.row  = r_r;
    end
    job.col  = c_emit[COL_W-1:0];
    job.last = (pend_clr == '0);
    job.done = done_r;
  end

  assign job_valid = (state_r == ST_EMIT);
  assign job_take  = job_valid && job_ready;

  bfc_mean u_mean (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (job_valid),
    .job         (job),
    .job_ready   (job_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .smoothed    (out_smoothed),
    .out_row     (out_out_row),
    .out_col     (out_out_col),
    .last_of_run (out_last_of_run),
    .frame_done  (out_frame_done)
  );

  // Sequencer and position counters.
  always_comb begin
    state_nxt   = state_r;
    pend_nxt    = pend_r;
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        pend_nxt  = mask;
        state_nxt = (mask == '0) ? ST_IDLE : ST_EMIT;
        if (row_end) begin
          col_cnt_nxt = '0;
          row_cnt_nxt = last_row ? '0 : (r_r + ROW_W'(1));
        end else begin
          col_cnt_nxt = c_r + CW'(1);
          row_cnt_nxt = r_r;
        end
      end
      ST_EMIT: begin
        if (job_take) begin
          pend_nxt = pend_clr;
          if (pend_clr == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      pend_r         <= '0;
      row_cnt_r      <= '0;
      col_cnt_r      <= '0;
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      for (int i = 0; i < 3; i++) begin
        win_r[i] <= '0;
        low_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      pend_r    <= pend_nxt;
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FW_W-1:0];
          CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FH_W-1:0];
          default: ;
        endcase
      end
      if (load) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= up_sum;
        low_r[0] <= low_r[1];
        low_r[1] <= low_r[2];
        low_r[2] <= lo_sum;
      end
    end
  end

  // Item registers, loaded when the pixel is taken or the memory data returns.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r <= in_pixel_in;
      r_r  <= start_r;
      c_r  <= start_c;
    end
    if (load) begin
      done_r <= row_end && last_row;
    end
  end

endmodule

FILE: rtl/bfc_checker.sv
// Port-level checker for the box filter, bound to its top level.
module bfc_checker
  import bfc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PIX_W-1:0] out_smoothed,
  input logic [ROW_W-1:0] out_out_row,
  input logic [COL_W-1:0] out_out_col,
  input logic             out_last_of_run,
  input logic             out_frame_done
);

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // No item is taken in the cycle after another is taken.
  a_input_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken on consecutive cycles");

  // A stalled result keeps all of its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_smoothed) && $stable(out_out_row)
      && $stable(out_out_col) && $stable(out_last_of_run) && $stable(out_frame_done))
    else $error("stalled result changed");

endmodule

bind box_filter_3x3_clamped_mean_unit bfc_checker u_bfc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_smoothed    (out_smoothed),
  .out_out_row     (out_out_row),
  .out_out_col     (out_out_col),
  .out_last_of_run (out_last_of_run),
  .out_frame_done  (out_frame_done)
);
